// ----- hw/rtl/dsrg_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Disk scrub request generator package
// Shared constants, register indexes and the control structs that pass
// between the sequencer, the arithmetic unit and the chunk emitter.
// ----------------------------------------------------------------------------
package dsrg_pkg;

   localparam int SECTOR_BITS_DEF = 48;
   localparam int CHUNK_MAX_DEF   = 65535;

   localparam int SEG_W      = 21;
   localparam int REGION_W   = 32;
   localparam int BOUND_W    = 32;
   localparam int COUNT_W    = 16;
   localparam int ISSUED_W   = 33;
   localparam int OPND_W     = 32;
   localparam int RESULTS_MAX = 17;
   localparam int K_W        = 5;
   localparam int CSR_INDEX_W = 3;

   localparam logic [SEG_W-1:0]    SEG_LIMIT    = 21'd1048576;
   localparam logic [SEG_W-1:0]    SEG_RESET    = 21'd128;
   localparam logic [REGION_W-1:0] REGION_RESET = 32'd131072;

   localparam logic [CSR_INDEX_W-1:0] CSR_STRATEGY = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_START    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_END      = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEGMENT  = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REGION   = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_BOUND    = 3'd5;

   localparam logic MODE_BEGIN = 1'b0;
   localparam logic MODE_NEXT  = 1'b1;

   localparam logic STRAT_SEQUENTIAL = 1'b0;
   localparam logic STRAT_STAGGERED  = 1'b1;

   typedef enum logic {
      ARITH_DIV = 1'b0,
      ARITH_MUL = 1'b1
   } arith_op_type;

   typedef struct packed {
      logic         start;
      arith_op_type op;
   } arith_cmd_type;

   typedef struct packed {
      logic             load;
      logic             issued;
      logic             round_done;
      logic [SEG_W-1:0] num;
   } chunk_load_type;

endpackage

// ----- hw/rtl/dsrg_req_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel that carries one scrub request item.
// ----------------------------------------------------------------------------
interface dsrg_req_if;

   logic valid;
   logic ready;
   logic mode;
   logic stop_request;

   modport source (output valid, output mode, output stop_request, input ready);
   modport sink   (input valid, input mode, input stop_request, output ready);

endinterface

// ----- hw/rtl/dsrg_rsp_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel that carries one verify command or status result.
// ----------------------------------------------------------------------------
interface dsrg_rsp_if #(
   parameter int SECTOR_BITS = dsrg_pkg::SECTOR_BITS_DEF
);

   logic                             valid;
   logic                             ready;
   logic                             issued;
   logic [SECTOR_BITS-1:0]           verify_sector;
   logic [dsrg_pkg::COUNT_W-1:0]     verify_count;
   logic                             last_chunk;
   logic                             round_done;

   modport source (output valid, output issued, output verify_sector, output verify_count,
                   output last_chunk, output round_done, input ready);
   modport sink   (input valid, input issued, input verify_sector, input verify_count,
                   input last_chunk, input round_done, output ready);

endinterface

// ----- hw/rtl/disk_scrub_request_generator.sv -----
`timescale 1ns / 1ps
// A begin request runs two divisions of SECTOR_BITS steps each in the shared
// arithmetic unit; a sequential next request needs no arithmetic, and a staggered
// one makes up to four search rounds of two 32-step multiplications each.
// One request at a time; ready returns as its result loads, chunks leave one per cycle
// while the response channel is ready.
// Synchronous reset clears the state, cursor, indexes, totals and active flag and loads the register defaults.
// ----------------------------------------------------------------------------
// Disk scrub request generator
// Produces the verify commands of a scrub round in sequential or staggered
// order, under a small sequencer that drives one shared arithmetic unit.
// ----------------------------------------------------------------------------
module disk_scrub_request_generator #(
   parameter int SECTOR_BITS = dsrg_pkg::SECTOR_BITS_DEF,
   parameter int CHUNK_MAX   = dsrg_pkg::CHUNK_MAX_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_write_enable,
   input  logic [dsrg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [((SECTOR_BITS > 32) ? SECTOR_BITS : 32)-1:0] csr_write_data,
   dsrg_req_if.sink                             req_chan,
   dsrg_rsp_if.source                           rsp_chan
);

   localparam int SB  = SECTOR_BITS;
   localparam int SW  = dsrg_pkg::SEG_W;
   localparam int RW  = dsrg_pkg::REGION_W;
   localparam int BW  = dsrg_pkg::BOUND_W;
   localparam int IW  = dsrg_pkg::ISSUED_W;
   localparam int OW  = dsrg_pkg::OPND_W;
   localparam int PW  = SB + OW;
   localparam logic [1:0] GUARD_LAST = 2'd3;

   typedef enum logic [9:0] {
      S_IDLE  = 10'b0000000001,
      S_BEG1  = 10'b0000000010,
      S_BEG2  = 10'b0000000100,
      S_NEXT  = 10'b0000001000,
      S_SEQ   = 10'b0000010000,
      S_FIND  = 10'b0000100000,
      S_MUL1  = 10'b0001000000,
      S_MUL2  = 10'b0010000000,
      S_FINAL = 10'b0100000000,
      S_HAND  = 10'b1000000000
   } state_type;

   // Configuration registers
   logic            strategy_ff, strategy_in;
   logic [SB-1:0]   start_ff, start_in;
   logic [SB-1:0]   end_ff, end_in;
   logic [SW-1:0]   seg_cfg_ff, seg_cfg_in;
   logic [RW-1:0]   region_cfg_ff, region_cfg_in;
   logic [BW-1:0]   bound_ff, bound_in;

   // Round state
   state_type       state_ff, state_in;
   logic [SB-1:0]   cursor_ff, cursor_in;
   logic [31:0]     seg_idx_ff, seg_idx_in;
   logic [SB-1:0]   reg_idx_ff, reg_idx_in;
   logic [SB-1:0]   reg_total_ff, reg_total_in;
   logic [31:0]     seg_total_ff, seg_total_in;
   logic [IW-1:0]   issued_total_ff, issued_total_in;
   logic            active_ff, active_in;
   logic [1:0]      guard_ff, guard_in;
   logic            stop_ff, stop_in;
   logic            more_ff, more_in;
   logic [SW-1:0]   num_ff, num_in;
   logic [SB-1:0]   pos_ff, pos_in;
   logic [SB-1:0]   rest_ff, rest_in;
   logic [SB-1:0]   base_ff, base_in;
   logic            res_issued_ff, res_issued_in;
   logic            res_done_ff, res_done_in;

   // Derived values
   logic [SW-1:0]   seg_size;
   logic [RW-1:0]   reg_size;
   logic [SB-1:0]   range_len;
   logic [SB-1:0]   cur_left;
   logic [SB-1:0]   seq_next;
   logic            req_take;
   logic            over_bound;

   // Arithmetic unit and chunk emitter connections
   dsrg_pkg::arith_cmd_type   arith_cmd;
   logic [SB-1:0]             arith_a;
   logic [OW-1:0]             arith_b;
   logic                      arith_done;
   logic [SB-1:0]             arith_hi;
   logic [OW-1:0]             arith_lo;
   logic [PW-1:0]             arith_prod;
   logic                      arith_rem_nz;
   dsrg_pkg::chunk_load_type  chunk_load;
   logic                      chunk_ready;

   assign seg_size = (seg_cfg_ff == '0) ? SW'(1)
                   : (seg_cfg_ff > dsrg_pkg::SEG_LIMIT) ? dsrg_pkg::SEG_LIMIT : seg_cfg_ff;
   assign reg_size   = (region_cfg_ff == '0) ? RW'(1) : region_cfg_ff;
   assign range_len  = (end_ff > start_ff) ? (end_ff - start_ff) : '0;
   assign cur_left   = end_ff - cursor_ff;
   assign seq_next   = cursor_ff + SB'(num_ff);
   assign req_take   = req_chan.valid && req_chan.ready;
   assign over_bound = (bound_ff != '0) && (issued_total_ff > IW'(bound_ff));
   assign arith_prod   = {arith_hi, arith_lo};
   assign arith_rem_nz = arith_lo != '0;

   assign req_chan.ready = (state_ff == S_IDLE);

   // Configuration writes
   always_comb begin
      strategy_in   = strategy_ff;
      start_in      = start_ff;
      end_in        = end_ff;
      seg_cfg_in    = seg_cfg_ff;
      region_cfg_in = region_cfg_ff;
      bound_in      = bound_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            dsrg_pkg::CSR_STRATEGY: strategy_in   = csr_write_data[0];
            dsrg_pkg::CSR_START:    start_in      = csr_write_data[SB-1:0];
            dsrg_pkg::CSR_END:      end_in        = csr_write_data[SB-1:0];
            dsrg_pkg::CSR_SEGMENT:  seg_cfg_in    = csr_write_data[SW-1:0];
            dsrg_pkg::CSR_REGION:   region_cfg_in = csr_write_data[RW-1:0];
            dsrg_pkg::CSR_BOUND:    bound_in      = csr_write_data[BW-1:0];
            default: ;
         endcase
      end
   end

   // Sequencer
   always_comb begin
      state_in        = state_ff;
      cursor_in       = cursor_ff;
      seg_idx_in      = seg_idx_ff;
      reg_idx_in      = reg_idx_ff;
      reg_total_in    = reg_total_ff;
      seg_total_in    = seg_total_ff;
      issued_total_in = issued_total_ff;
      active_in       = active_ff;
      guard_in        = guard_ff;
      stop_in         = stop_ff;
      more_in         = more_ff;
      num_in          = num_ff;
      pos_in          = pos_ff;
      rest_in         = rest_ff;
      base_in         = base_ff;
      res_issued_in   = res_issued_ff;
      res_done_in     = res_done_ff;
      arith_cmd       = '{start: 1'b0, op: dsrg_pkg::ARITH_DIV};
      arith_a         = '0;
      arith_b         = '0;
      chunk_load      = '{load: 1'b0, issued: res_issued_ff, round_done: res_done_ff,
                          num: num_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               stop_in = req_chan.stop_request;
               if (req_chan.mode == dsrg_pkg::MODE_BEGIN) begin
                  arith_cmd = '{start: 1'b1, op: dsrg_pkg::ARITH_DIV};
                  arith_a   = range_len;
                  arith_b   = OW'(reg_size);
                  state_in  = S_BEG1;
               end else if (!active_ff || (cursor_ff >= end_ff)) begin
                  active_in     = 1'b0;
                  res_issued_in = 1'b0;
                  res_done_in   = 1'b1;
                  num_in        = '0;
                  pos_in        = '0;
                  state_in      = S_HAND;
               end else begin
                  state_in = S_NEXT;
               end
            end
         end

         S_BEG1: begin
            if (arith_done) begin
               // Region count rounds up.
               reg_total_in = arith_hi + SB'(arith_rem_nz);
               arith_cmd    = '{start: 1'b1, op: dsrg_pkg::ARITH_DIV};
               arith_a      = SB'(reg_size);
               arith_b      = OW'(seg_size);
               state_in     = S_BEG2;
            end
         end

         S_BEG2: begin
            if (arith_done) begin
               seg_total_in    = arith_hi[31:0] + 32'(arith_rem_nz);
               cursor_in       = start_ff;
               seg_idx_in      = '0;
               reg_idx_in      = '0;
               issued_total_in = '0;
               active_in       = start_ff < end_ff;
               res_issued_in   = 1'b0;
               res_done_in     = !(start_ff < end_ff);
               num_in          = '0;
               pos_in          = '0;
               state_in        = S_HAND;
            end
         end

         S_NEXT: begin
            num_in = (cur_left > SB'(seg_size)) ? seg_size : cur_left[SW-1:0];
            pos_in = cursor_ff;
            if (issued_total_ff != '1) begin
               issued_total_in = issued_total_ff + IW'(1);
            end
            if (strategy_ff == dsrg_pkg::STRAT_SEQUENTIAL) begin
               state_in = S_SEQ;
            end else begin
               reg_idx_in = reg_idx_ff + SB'(1);
               guard_in   = '0;
               state_in   = S_FIND;
            end
         end

         S_SEQ: begin
            cursor_in = seq_next;
            more_in   = seq_next < end_ff;
            state_in  = S_FINAL;
         end

         S_FIND: begin
            if (seg_idx_ff >= seg_total_ff) begin
               more_in  = 1'b0;
               state_in = S_FINAL;
            end else if (reg_idx_ff >= reg_total_ff) begin
               // Past the last region: move on to the next segment row.
               reg_idx_in = '0;
               seg_idx_in = seg_idx_ff + 32'd1;
               if (guard_ff == GUARD_LAST) begin
                  more_in  = 1'b0;
                  state_in = S_FINAL;
               end else begin
                  guard_in = guard_ff + 2'd1;
               end
            end else begin
               arith_cmd = '{start: 1'b1, op: dsrg_pkg::ARITH_MUL};
               arith_a   = reg_idx_ff;
               arith_b   = OW'(reg_size);
               state_in  = S_MUL1;
            end
         end

         S_MUL1: begin
            if (arith_done) begin
               if (arith_prod >= PW'(range_len)) begin
                  if (reg_idx_ff == '0) begin
                     more_in  = 1'b0;
                     state_in = S_FINAL;
                  end else begin
                     reg_idx_in = '0;
                     seg_idx_in = seg_idx_ff + 32'd1;
                     if (guard_ff == GUARD_LAST) begin
                        more_in  = 1'b0;
                        state_in = S_FINAL;
                     end else begin
                        guard_in = guard_ff + 2'd1;
                        state_in = S_FIND;
                     end
                  end
               end else begin
                  rest_in   = range_len - arith_prod[SB-1:0];
                  base_in   = start_ff + arith_prod[SB-1:0];
                  arith_cmd = '{start: 1'b1, op: dsrg_pkg::ARITH_MUL};
                  arith_a   = SB'(seg_idx_ff);
                  arith_b   = OW'(seg_size);
                  state_in  = S_MUL2;
               end
            end
         end

         S_MUL2: begin
            if (arith_done) begin
               if (arith_prod >= PW'(rest_ff)) begin
                  if (reg_idx_ff == '0) begin
                     more_in  = 1'b0;
                     state_in = S_FINAL;
                  end else begin
                     reg_idx_in = '0;
                     seg_idx_in = seg_idx_ff + 32'd1;
                     if (guard_ff == GUARD_LAST) begin
                        more_in  = 1'b0;
                        state_in = S_FINAL;
                     end else begin
                        guard_in = guard_ff + 2'd1;
                        state_in = S_FIND;
                     end
                  end
               end else begin
                  cursor_in = base_ff + arith_prod[SB-1:0];
                  more_in   = 1'b1;
                  state_in  = S_FINAL;
               end
            end
         end

         S_FINAL: begin
            active_in     = more_ff && !stop_ff && !over_bound;
            res_issued_in = 1'b1;
            res_done_in   = !(more_ff && !stop_ff && !over_bound);
            state_in      = S_HAND;
         end

         S_HAND: begin
            chunk_load.load = chunk_ready;
            if (chunk_ready) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         strategy_ff     <= dsrg_pkg::STRAT_SEQUENTIAL;
         start_ff        <= '0;
         end_ff          <= '0;
         seg_cfg_ff      <= dsrg_pkg::SEG_RESET;
         region_cfg_ff   <= dsrg_pkg::REGION_RESET;
         bound_ff        <= '0;
         state_ff        <= S_IDLE;
         cursor_ff       <= '0;
         seg_idx_ff      <= '0;
         reg_idx_ff      <= '0;
         reg_total_ff    <= '0;
         seg_total_ff    <= '0;
         issued_total_ff <= '0;
         active_ff       <= 1'b0;
      end else begin
         strategy_ff     <= strategy_in;
         start_ff        <= start_in;
         end_ff          <= end_in;
         seg_cfg_ff      <= seg_cfg_in;
         region_cfg_ff   <= region_cfg_in;
         bound_ff        <= bound_in;
         state_ff        <= state_in;
         cursor_ff       <= cursor_in;
         seg_idx_ff      <= seg_idx_in;
         reg_idx_ff      <= reg_idx_in;
         reg_total_ff    <= reg_total_in;
         seg_total_ff    <= seg_total_in;
         issued_total_ff <= issued_total_in;
         active_ff       <= active_in;
      end
      guard_ff      <= guard_in;
      stop_ff       <= stop_in;
      more_ff       <= more_in;
      num_ff        <= num_in;
      pos_ff        <= pos_in;
      rest_ff       <= rest_in;
      base_ff       <= base_in;
      res_issued_ff <= res_issued_in;
      res_done_ff   <= res_done_in;
   end

   dsrg_arith #(
      .SECTOR_BITS (SECTOR_BITS)
   ) u_arith (
      .clock     (clock),
      .reset     (reset),
      .cmd       (arith_cmd),
      .opnd_a    (arith_a),
      .opnd_b    (arith_b),
      .done      (arith_done),
      .result_hi (arith_hi),
      .result_lo (arith_lo)
   );

   dsrg_chunk #(
      .SECTOR_BITS (SECTOR_BITS),
      .CHUNK_MAX   (CHUNK_MAX)
   ) u_chunk (
      .clock       (clock),
      .reset       (reset),
      .load        (chunk_load),
      .load_sector (pos_ff),
      .load_ready  (chunk_ready),
      .rsp_chan    (rsp_chan)
   );

   // Results of the arithmetic unit are only ever awaited in the compute states.
   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      arith_done |-> (state_ff == S_BEG1 || state_ff == S_BEG2 ||
                      state_ff == S_MUL1 || state_ff == S_MUL2))
      else $error("arithmetic result arrived outside a compute state");

   // A running round always has at least one region and one segment per region.
   // The totals are rewritten during a begin request, so only idle cycles are checked.
   a_active_sizes: assert property (@(posedge clock) disable iff (reset)
      (active_ff && state_ff == S_IDLE) |-> (seg_total_ff != '0) && (reg_total_ff != '0))
      else $error("round active with empty region or segment count");

endmodule

// ----- hw/rtl/dsrg_arith.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Shared arithmetic unit
// Iterative restoring divider and shift-add multiplier sharing one pair of
// working registers. Division takes SECTOR_BITS steps, multiplication 32.
// ----------------------------------------------------------------------------
module dsrg_arith #(
   parameter int SECTOR_BITS = dsrg_pkg::SECTOR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  dsrg_pkg::arith_cmd_type       cmd,
   input  logic [SECTOR_BITS-1:0]        opnd_a,
   input  logic [dsrg_pkg::OPND_W-1:0]   opnd_b,
   output logic                          done,
   output logic [SECTOR_BITS-1:0]        result_hi,
   output logic [dsrg_pkg::OPND_W-1:0]   result_lo
);

   localparam int CNT_W = $clog2(SECTOR_BITS);
   localparam int OW    = dsrg_pkg::OPND_W;

   // For division hi holds the dividend shifting into the quotient and lo the
   // remainder; for multiplication hi is the accumulator and lo the multiplier.
   logic [SECTOR_BITS-1:0]  hi_ff, hi_in;
   logic [OW-1:0]           lo_ff, lo_in;
   logic [SECTOR_BITS-1:0]  opnd_ff, opnd_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   dsrg_pkg::arith_op_type  op_ff, op_in;
   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;

   logic [OW:0]             trial;
   logic [OW:0]             trial_diff;
   logic                    trial_ge;
   logic [SECTOR_BITS:0]    mul_sum;
   logic [CNT_W-1:0]        cnt_last;

   assign trial      = {lo_ff, hi_ff[SECTOR_BITS-1]};
   assign trial_diff = trial - {1'b0, opnd_ff[OW-1:0]};
   assign trial_ge   = trial >= {1'b0, opnd_ff[OW-1:0]};
   assign mul_sum    = {1'b0, hi_ff} + (lo_ff[0] ? {1'b0, opnd_ff} : '0);
   assign cnt_last   = (op_ff == dsrg_pkg::ARITH_DIV) ? CNT_W'(SECTOR_BITS - 1)
                                                      : CNT_W'(OW - 1);

   always_comb begin
      hi_in   = hi_ff;
      lo_in   = lo_ff;
      opnd_in = opnd_ff;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (cmd.start) begin
         op_in   = cmd.op;
         cnt_in  = '0;
         busy_in = 1'b1;
         if (cmd.op == dsrg_pkg::ARITH_DIV) begin
            hi_in   = opnd_a;
            lo_in   = '0;
            opnd_in = SECTOR_BITS'(opnd_b);
         end else begin
            hi_in   = '0;
            lo_in   = opnd_b;
            opnd_in = opnd_a;
         end
      end else if (busy_ff) begin
         if (op_ff == dsrg_pkg::ARITH_DIV) begin
            hi_in = {hi_ff[SECTOR_BITS-2:0], trial_ge};
            lo_in = trial_ge ? trial_diff[OW-1:0] : trial[OW-1:0];
         end else begin
            hi_in = mul_sum[SECTOR_BITS:1];
            lo_in = {mul_sum[0], lo_ff[OW-1:1]};
         end
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == cnt_last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      hi_ff   <= hi_in;
      lo_ff   <= lo_in;
      opnd_ff <= opnd_in;
      cnt_ff  <= cnt_in;
      op_ff   <= op_in;
   end

   assign done      = done_ff;
   assign result_hi = hi_ff;
   assign result_lo = lo_ff;

   // The sequencer must wait for completion before issuing the next operation.
   a_start_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.start |-> !busy_ff)
      else $error("arithmetic unit started while busy");

endmodule

// ----- hw/rtl/dsrg_chunk.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Chunk emitter
// Holds one segment and presents it on the response channel as a run of
// verify chunks (at most RESULTS_MAX) of at most CHUNK_MAX sectors, or as a single status result.
// ----------------------------------------------------------------------------
module dsrg_chunk #(
   parameter int SECTOR_BITS = dsrg_pkg::SECTOR_BITS_DEF,
   parameter int CHUNK_MAX   = dsrg_pkg::CHUNK_MAX_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  dsrg_pkg::chunk_load_type   load,
   input  logic [SECTOR_BITS-1:0]     load_sector,
   output logic                       load_ready,
   dsrg_rsp_if.source                 rsp_chan
);

   localparam int SW = dsrg_pkg::SEG_W;
   localparam int CW = dsrg_pkg::COUNT_W;
   localparam int KW = dsrg_pkg::K_W;

   logic [SW-1:0]           left_ff, left_in;
   logic [SECTOR_BITS-1:0]  pos_ff, pos_in;
   logic [KW-1:0]           k_ff, k_in;
   logic                    issued_ff, issued_in;
   logic                    done_ff, done_in;
   logic                    busy_ff, busy_in;

   logic                    over_max;
   logic [CW-1:0]           chunk_n;
   logic                    is_last;
   logic                    take;

   assign over_max = left_ff > SW'(CHUNK_MAX);
   assign chunk_n  = over_max ? CW'(CHUNK_MAX) : left_ff[CW-1:0];
   assign is_last  = !issued_ff || !over_max || (k_ff == KW'(dsrg_pkg::RESULTS_MAX - 1));
   assign take     = busy_ff && rsp_chan.ready;

   always_comb begin
      left_in   = left_ff;
      pos_in    = pos_ff;
      k_in      = k_ff;
      issued_in = issued_ff;
      done_in   = done_ff;
      busy_in   = busy_ff;
      if (take) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else begin
            left_in = left_ff - SW'(chunk_n);
            pos_in  = pos_ff + SECTOR_BITS'(chunk_n);
            k_in    = k_ff + KW'(1);
         end
      end
      if (load.load && !busy_ff) begin
         left_in   = load.num;
         pos_in    = load_sector;
         k_in      = '0;
         issued_in = load.issued;
         done_in   = load.round_done;
         busy_in   = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
      end
      left_ff   <= left_in;
      pos_ff    <= pos_in;
      k_ff      <= k_in;
      issued_ff <= issued_in;
      done_ff   <= done_in;
   end

   assign load_ready             = !busy_ff;
   assign rsp_chan.valid         = busy_ff;
   assign rsp_chan.issued        = issued_ff;
   assign rsp_chan.verify_sector = pos_ff;
   assign rsp_chan.verify_count  = chunk_n;
   assign rsp_chan.last_chunk    = is_last;
   assign rsp_chan.round_done    = done_ff;

   a_chunk_count_bounded: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (k_ff < KW'(dsrg_pkg::RESULTS_MAX)))
      else $error("chunk run longer than the result limit");

   // A status result carries no sectors, so its loaded sector count must be zero.
   a_status_single: assert property (@(posedge clock) disable iff (reset)
      (busy_ff && !issued_ff) |-> (left_ff == '0))
      else $error("status result loaded with a sector count");

endmodule
